@@ hw/rtl/gpm_pkg.sv @@
// gpm_pkg: shared types and constants of the grid power metering block
// used by gpm_ctrl, gpm_dp and grid_power_metering_top; no dependencies
package gpm_pkg;

    localparam int SQRT_STEPS = 28;
    localparam int DIV_STEPS  = 16;
    localparam int CNT_W      = 5;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 240;

    localparam logic [1:0] REG_GV_GAIN = 2'd0;
    localparam logic [1:0] REG_GI_GAIN = 2'd1;
    localparam logic [1:0] REG_MIN_APP = 2'd2;

    localparam logic [31:0] GAIN_RESET    = 32'h0100_0000;
    localparam logic [31:0] MIN_APP_RESET = 32'h0001_0000;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SQ_INIT,
        DP_SQ_STEP,
        DP_MUL,
        DP_WR,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_PF,
        DP_OUT
    } t_dp_op;

    typedef enum logic [2:0] {
        SEL_VRMS,
        SEL_IRMS,
        SEL_GAIN,
        SEL_ALO,
        SEL_AHI,
        SEL_RLO,
        SEL_RHI,
        SEL_APP
    } t_dp_sel;

    typedef struct packed {
        t_dp_op  op;
        t_dp_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic fast;
        logic out_busy;
    } t_dp_sts;

    typedef struct packed {
        logic [31:0] gv_gain;
        logic [31:0] gi_gain;
        logic [31:0] min_app;
    } t_cfg;

endpackage

@@ hw/rtl/grid_power_metering_top.sv @@
// grid_power_metering_top: rms, power and power factor metering
// depends on gpm_pkg, gpm_ctrl and gpm_dp
//
// usage
// one input transfer on the s channel carries four means: tdata holds
// grid_volt_mean_sq, induct_curr_mean_sq, active_mean, reactive_mean, and
// tuser holds fast_update. each input gives exactly one result transfer on
// the m channel with both rms values, the held powers, power factor and
// the measurement sequence count.
// a new input is taken only after the previous result has been loaded,
// never while one is in flight. each item runs two 28-step square roots
// on one shared root unit; fast update adds the three powers and the
// 16-step power factor divide. the result sits in an output register, so
// a stalled receiver holds only the following item at its final step, not
// the one in flight. reset clears the held powers, factor, sequence count
// and the controller; gain and threshold registers return to 1.0, 1.0
// and 1 VA. configuration: apb registers at 0x0, 0x4, 0x8 are to be
// written only while idle; the user must keep to this, the block does not.
module grid_power_metering_top import gpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // grid_volt_mean_sq, induct_curr_mean_sq, active_mean, reactive_mean
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // fast_update
    input  logic                  i_s_tuser,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // grid_volt_rms, induct_curr_rms, active_power, reactive_power,
    // apparent_power, power_factor, measure_sequence, one pad bit
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [3:0]            i_paddr,
    input  logic [31:0]           i_pwdata,
    output logic [31:0]           o_prdata,
    output logic                  o_pready
);

    logic [31:0] r_gv_gain, r_gi_gain, r_min_app;
    t_cfg        cfg;
    t_dp_cmd     cmd;
    t_dp_sts     sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv_gain <= GAIN_RESET;
            r_gi_gain <= GAIN_RESET;
            r_min_app <= MIN_APP_RESET;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (i_paddr[3:2])
                REG_GV_GAIN: r_gv_gain <= i_pwdata;
                REG_GI_GAIN: r_gi_gain <= i_pwdata;
                REG_MIN_APP: r_min_app <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_GV_GAIN: o_prdata = r_gv_gain;
            REG_GI_GAIN: o_prdata = r_gi_gain;
            REG_MIN_APP: o_prdata = r_min_app;
            default:     o_prdata = '0;
        endcase
    end

    assign o_pready    = 1'b1;
    assign cfg.gv_gain = r_gv_gain;
    assign cfg.gi_gain = r_gi_gain;
    assign cfg.min_app = r_min_app;

    gpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gpm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_in_data   (i_s_tdata),
        .i_in_fast   (i_s_tuser),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while item in flight");

    a_pf_needs_apparent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[222:207] != '0) |-> (o_m_tdata[206:160] != '0))
        else $error("power factor without apparent power");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");
`endif

endmodule

@@ hw/rtl/gpm_ctrl.sv @@
// gpm_ctrl: sequencer for the metering datapath
// depends on gpm_pkg; drives gpm_dp through t_dp_cmd, reads t_dp_sts
module gpm_ctrl import gpm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_INIT,
        S_SQ,
        S_MUL,
        S_WR,
        S_DIV_INIT,
        S_DIV,
        S_PF,
        S_OUT
    } t_state;

    t_state             r_state, n_state;
    t_dp_sel            r_sel, n_sel;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_cnt   = r_cnt;
        o_cmd   = '{op: DP_NOP, sel: r_sel};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_sel    = SEL_VRMS;
                    n_state  = S_SQ_INIT;
                end
            end
            S_SQ_INIT: begin
                o_cmd.op = DP_SQ_INIT;
                n_cnt    = CNT_W'(SQRT_STEPS - 1);
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = DP_SQ_STEP;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = DP_MUL;
                n_state  = S_WR;
            end
            S_WR: begin
                o_cmd.op = DP_WR;
                n_state  = S_MUL;
                case (r_sel)
                    SEL_VRMS: begin
                        n_sel   = SEL_IRMS;
                        n_state = S_SQ_INIT;
                    end
                    SEL_IRMS: begin
                        n_sel   = SEL_GAIN;
                        n_state = i_sts.fast ? S_MUL : S_OUT;
                    end
                    SEL_GAIN: n_sel = SEL_ALO;
                    SEL_ALO:  n_sel = SEL_AHI;
                    SEL_AHI:  n_sel = SEL_RLO;
                    SEL_RLO:  n_sel = SEL_RHI;
                    SEL_RHI:  n_sel = SEL_APP;
                    SEL_APP:  n_state = S_DIV_INIT;
                    default:  n_state = S_OUT;
                endcase
            end
            S_DIV_INIT: begin
                o_cmd.op = DP_DIV_INIT;
                n_cnt    = CNT_W'(DIV_STEPS - 1);
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_PF;
                end
            end
            S_PF: begin
                o_cmd.op = DP_PF;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_VRMS;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/gpm_dp.sv @@
// gpm_dp: metering datapath with shared square root, multiplier and divider
// depends on gpm_pkg; commanded by gpm_ctrl
module gpm_dp import gpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_cfg                  i_cfg,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_fast,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam logic [47:0] P_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] P_MIN = 48'h8000_0000_0000;
    localparam logic [46:0] S_MAX = '1;

    logic [31:0] r_ms_v, r_ms_i, r_am_mag, r_rm_mag, r_gv_mag, r_gi_mag;
    logic        r_am_neg, r_rm_neg, r_gneg, r_fast;
    logic [55:0] r_xsh;
    logic [27:0] r_root;
    logic [29:0] r_rem;
    logic [63:0] r_prod, r_gmag;
    logic [31:0] r_lo;
    logic [31:0] r_vrms, r_irms;
    logic [47:0] r_act, r_rea;
    logic [46:0] r_app;
    logic [15:0] r_pf, r_seq;
    logic [48:0] r_drem;
    logic [15:0] r_dbit, r_quo;
    logic        r_pf_en, r_ovf, r_pneg;
    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [47:0] pow_sat(input logic [55:0] q, input logic neg);
        logic [47:0] res;
        if (neg && q != '0) begin
            res = (q > 56'(P_MIN)) ? P_MIN : (48'd0 - q[47:0]);
        end else begin
            res = (q > 56'(P_MAX)) ? P_MAX : q[47:0];
        end
        pow_sat = res;
    endfunction

    // shared sqrt step
    logic [30:0] sq_rs, sq_trial;
    logic        sq_ge;
    assign sq_rs    = {r_rem[28:0], r_xsh[55:54]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_rs >= sq_trial);

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    always_comb begin
        case (i_cmd.sel)
            SEL_VRMS: begin mul_a = {4'd0, r_root}; mul_b = r_gv_mag; end
            SEL_IRMS: begin mul_a = {4'd0, r_root}; mul_b = r_gi_mag; end
            SEL_GAIN: begin mul_a = r_gv_mag; mul_b = r_gi_mag; end
            SEL_ALO:  begin mul_a = r_am_mag; mul_b = r_gmag[31:0]; end
            SEL_AHI:  begin mul_a = r_am_mag; mul_b = r_gmag[63:32]; end
            SEL_RLO:  begin mul_a = r_rm_mag; mul_b = r_gmag[31:0]; end
            SEL_RHI:  begin mul_a = r_rm_mag; mul_b = r_gmag[63:32]; end
            SEL_APP:  begin mul_a = r_vrms; mul_b = r_irms; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    logic [31:0] rms_sat;
    logic [63:0] hi_sum;
    logic [47:0] s_ext;
    assign rms_sat = (|r_prod[63:56]) ? '1 : r_prod[55:24];
    assign hi_sum  = r_prod + {32'd0, r_lo};
    assign s_ext   = {1'b0, r_app};

    // shared divider step
    logic [48:0] dv_rs;
    logic        dv_ge;
    assign dv_rs = {r_drem[47:0], r_dbit[15]};
    assign dv_ge = (dv_rs >= {2'd0, r_app});

    logic [47:0] pm;
    assign pm = r_act[47] ? (48'd0 - r_act) : r_act;

    logic [16:0] pf_q;
    logic [15:0] pf_val;
    always_comb begin
        pf_q = r_ovf ? 17'h10000 : {1'b0, r_quo};
        if (!r_pf_en) begin
            pf_val = '0;
        end else if (r_pneg) begin
            pf_val = (pf_q > 17'h08000) ? 16'h8000 : (16'd0 - pf_q[15:0]);
        end else begin
            pf_val = (pf_q > 17'h07FFF) ? 16'h7FFF : pf_q[15:0];
        end
    end

    logic [15:0] seq_next;
    assign seq_next = r_seq + 1'b1;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_ms_v   <= i_in_data[31:0];
                r_ms_i   <= i_in_data[63:32];
                r_am_mag <= mag32(i_in_data[95:64]);
                r_am_neg <= i_in_data[95];
                r_rm_mag <= mag32(i_in_data[127:96]);
                r_rm_neg <= i_in_data[127];
                r_fast   <= i_in_fast;
                r_gv_mag <= mag32(i_cfg.gv_gain);
                r_gi_mag <= mag32(i_cfg.gi_gain);
                r_gneg   <= i_cfg.gv_gain[31] ^ i_cfg.gi_gain[31];
            end
            DP_SQ_INIT: begin
                r_xsh  <= {(i_cmd.sel == SEL_VRMS) ? r_ms_v : r_ms_i, 24'd0};
                r_root <= '0;
                r_rem  <= '0;
            end
            DP_SQ_STEP: begin
                r_xsh  <= {r_xsh[53:0], 2'b00};
                r_root <= {r_root[26:0], sq_ge};
                r_rem  <= sq_ge ? 30'(sq_rs - sq_trial) : 30'(sq_rs);
            end
            DP_MUL: r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
            DP_DIV_INIT: begin
                r_pneg  <= r_act[47];
                r_pf_en <= (r_app > {15'd0, i_cfg.min_app});
                r_ovf   <= (pm >= {s_ext[46:0], 1'b0});
                r_drem  <= {2'd0, pm[47:1]};
                r_dbit  <= {pm[0], 15'd0};
                r_quo   <= '0;
            end
            DP_DIV_STEP: begin
                r_drem <= dv_ge ? (dv_rs - {2'd0, r_app}) : dv_rs;
                r_quo  <= {r_quo[14:0], dv_ge};
                r_dbit <= {r_dbit[14:0], 1'b0};
            end
            DP_OUT: begin
                r_out <= {1'b0, seq_next, r_pf, r_app, r_rea, r_act, r_irms, r_vrms};
            end
            default: ;
        endcase
        if (i_cmd.op == DP_WR) begin
            case (i_cmd.sel)
                SEL_VRMS: r_vrms <= rms_sat;
                SEL_IRMS: r_irms <= rms_sat;
                SEL_GAIN: r_gmag <= r_prod;
                SEL_ALO, SEL_RLO: r_lo <= r_prod[63:32];
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_act       <= '0;
            r_rea       <= '0;
            r_app       <= '0;
            r_pf        <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_WR) begin
                case (i_cmd.sel)
                    SEL_AHI: r_act <= pow_sat(hi_sum[63:8], r_am_neg ^ r_gneg);
                    SEL_RHI: r_rea <= pow_sat(hi_sum[63:8], r_rm_neg ^ r_gneg);
                    SEL_APP: r_app <= r_prod[63] ? S_MAX : r_prod[62:16];
                    default: ;
                endcase
            end
            if (i_cmd.op == DP_PF) begin
                r_pf <= pf_val;
            end
            if (i_cmd.op == DP_OUT) begin
                r_seq       <= seq_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.fast     = r_fast;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule
